// File: rtl/stk_pkg.sv
// ----------------------------------------------------------------------------
// stk_pkg: shared types and constants of the seed-to-key unit
// Widths, reset values, register indexes and the item carried between cells.
// ----------------------------------------------------------------------------
package stk_pkg;

    localparam int unsigned WORD_W         = 32;
    localparam int unsigned NUM_CELLS      = 7;
    localparam int unsigned SHIFT_STEPS    = 35;
    localparam int unsigned STEPS_PER_CELL = SHIFT_STEPS / NUM_CELLS;
    localparam int unsigned TEA_HALF_STEPS = 4;
    localparam int unsigned CELL_IDX_W     = $clog2(NUM_CELLS);
    localparam int unsigned CFG_ADDR_W     = 2;

    localparam logic [WORD_W-1:0] TEA_DELTA    = 32'h9e37_79b9;
    localparam logic [WORD_W-1:0] MASK_ONE_RST = 32'h5c73_5c73;
    localparam logic [WORD_W-1:0] MASK_TWO_RST = 32'h5f73_5f73;
    localparam logic              ALG_RST      = 1'b1;

    // algorithm codes
    localparam logic ALG_TEA  = 1'b0;
    localparam logic ALG_MASK = 1'b1;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_ALG_SEL  = 2'd0,
        REG_MASK_ONE = 2'd1,
        REG_MASK_TWO = 2'd2
    } cfg_reg_t;

    // word a: shift register or v0, word b: mask or v1
    typedef struct packed {
        logic              alg;
        logic              level;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } stk_item_t;

endpackage

// File: rtl/seed_to_key_unit.sv
// ----------------------------------------------------------------------------
// seed_to_key_unit: security-access seed to key calculation
// Pipelined chain of seven cells, one seed accepted per clock while the output is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel carries one seed per transaction, tuser holds the level bit
//   (0 = level one, 1 = level two). m_ channel returns one key per seed,
//   in order.
//   cfg_we/cfg_addr/cfg_wdata write the algorithm select (0) and the two
//   shift masks (1, 2); write them only while no seed is in flight.
//   A seed passes the seven cell registers in turn on its way to m_tvalid;
//   each cell does five shift steps or, in the first four, one cipher half round.
//   Throughput is one seed per cycle while m_tready stays high.
//   The last cell is the output register. When the receiver stalls the
//   whole chain holds and s_tready drops; it can still take a seed in the
//   same cycle that the waiting key is taken.
//   Reset empties the chain and restores the register defaults: mask
//   algorithm, masks 0x5c735c73 and 0x5f735f73.
// ----------------------------------------------------------------------------
module seed_to_key_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [stk_pkg::WORD_W-1:0]         s_tdata,   // seed
    input  logic                               s_tuser,   // level
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [stk_pkg::WORD_W-1:0]         m_tdata,   // key
    input  logic                               cfg_we,
    input  logic [stk_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [stk_pkg::WORD_W-1:0]         cfg_wdata
);
    import stk_pkg::*;

    logic              alg_sel_reg;
    logic [WORD_W-1:0] mask_one_reg;
    logic [WORD_W-1:0] mask_two_reg;

    logic              advance;
    stk_item_t         entry_item;
    logic              cell_valid [NUM_CELLS+1];
    stk_item_t         cell_item  [NUM_CELLS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            alg_sel_reg  <= ALG_RST;
            mask_one_reg <= MASK_ONE_RST;
            mask_two_reg <= MASK_TWO_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_ALG_SEL:  alg_sel_reg  <= cfg_wdata[0];
                REG_MASK_ONE: mask_one_reg <= cfg_wdata;
                REG_MASK_TWO: mask_two_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    assign advance  = !m_tvalid || m_tready;
    assign s_tready = advance;

    always_comb begin
        entry_item.alg   = alg_sel_reg;
        entry_item.level = s_tuser;
        entry_item.a     = s_tdata;
        if (alg_sel_reg == ALG_MASK) begin
            entry_item.b = s_tuser ? mask_two_reg : mask_one_reg;
        end else begin
            entry_item.b = ~s_tdata;
        end
    end

    assign cell_valid[0] = s_tvalid;
    assign cell_item[0]  = entry_item;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        stk_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (advance),
            .cell_idx  (CELL_IDX_W'(g)),
            .in_valid  (cell_valid[g]),
            .in_item   (cell_item[g]),
            .out_valid (cell_valid[g+1]),
            .out_item  (cell_item[g+1])
        );
    end

    assign m_tvalid = cell_valid[NUM_CELLS];
    assign m_tdata  = cell_item[NUM_CELLS].a;

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> cell_valid[1])
        else $error("accepted seed did not enter the first cell");

    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> ($stable(cell_valid[1]) && $stable(cell_item[1])))
        else $error("chain moved while the output was stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// File: rtl/stk_cell.sv
// ----------------------------------------------------------------------------
// stk_cell: one cell of the key chain
// Runs five mask shift steps, or one half round of the two-round cipher when
// its place in the chain is one of the first four, and registers the item.
// ----------------------------------------------------------------------------
module stk_cell (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               en,
    input  logic [stk_pkg::CELL_IDX_W-1:0]     cell_idx,
    input  logic                               in_valid,
    input  stk_pkg::stk_item_t                 in_item,
    output logic                               out_valid,
    output stk_pkg::stk_item_t                 out_item
);
    import stk_pkg::*;

    logic      valid_reg;
    stk_item_t item_reg;
    stk_item_t item_next;

    function automatic logic [7:0] key_byte(input logic [1:0] idx, input logic level);
        logic [7:0] w;
        begin
            unique case (idx)
                2'd0: w = 8'h11;
                2'd1: w = 8'h22;
                2'd2: w = 8'h33;
                2'd3: w = 8'h44;
                default: w = 8'h11;
            endcase
            return level ? {w[2:0], w[7:3]} : w;
        end
    endfunction

    // sum plus key byte for each half round, folded to constants
    function automatic logic [WORD_W-1:0] tea_addend(input logic [1:0] step,
                                                     input logic level);
        logic [WORD_W-1:0] sum;
        logic [1:0]        kidx;
        begin
            unique case (step)
                2'd0: sum = '0;
                2'd1: sum = TEA_DELTA;
                2'd2: sum = TEA_DELTA;
                2'd3: sum = TEA_DELTA + TEA_DELTA;
                default: sum = '0;
            endcase
            kidx = step[0] ? sum[12:11] : sum[1:0];
            return sum + {24'd0, key_byte(kidx, level)};
        end
    endfunction

    function automatic logic [WORD_W-1:0] tea_mix(input logic [WORD_W-1:0] x);
        return ((x << 4) ^ (x >> 5)) + x;
    endfunction

    always_comb begin
        logic [WORD_W-1:0] v;
        logic [WORD_W-1:0] addend;
        item_next = in_item;
        v         = in_item.a;
        addend    = tea_addend(cell_idx[1:0], in_item.level);
        if (in_item.alg == ALG_MASK) begin
            for (int unsigned i = 0; i < STEPS_PER_CELL; i++) begin
                v = v[WORD_W-1] ? ((v << 1) ^ in_item.b) : (v << 1);
            end
            item_next.a = v;
        end else if (cell_idx < CELL_IDX_W'(TEA_HALF_STEPS)) begin
            if (cell_idx[0]) begin
                item_next.b = in_item.b + (tea_mix(in_item.a) ^ addend);
            end else begin
                item_next.a = in_item.a + (tea_mix(in_item.b) ^ addend);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule
